### rtl/core/soc_pkg.sv
// Shared types, codes and helpers for the signed overflow checker.
package soc_pkg;

  // Field widths of one item
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned RBITS_W = 7;
  localparam int unsigned LINE_W  = 32;
  localparam int unsigned SHAMT_W = 6;
  localparam int unsigned HALF_W  = DATA_W / 2;

  // Operand width actually used (8..64); operands sign-extend from its top bit
  localparam int unsigned OPERAND_BITS = 64;
  localparam int unsigned SEXT_SHIFT   = DATA_W - OPERAND_BITS;
  localparam logic [RBITS_W-1:0] OPERAND_BITS_R = RBITS_W'(OPERAND_BITS);

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_ADD = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SUB = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MUL = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DIV = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REM = 3'd4;

  typedef enum logic [1:0] {
    VERDICT_OK       = 2'd0,
    VERDICT_OVERFLOW = 2'd1,
    VERDICT_DIVZERO  = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic signed [DATA_W-1:0] left_operand;
    logic signed [DATA_W-1:0] right_operand;
    logic [RBITS_W-1:0] result_bits;
    logic [LINE_W-1:0]  source_line;
  } soc_in_t;

  typedef struct packed {
    verdict_t          verdict;
    logic [LINE_W-1:0] fault_line;
  } soc_out_t;

  // Partial products plus everything the later stages need
  typedef struct packed {
    logic               valid;
    logic               is_mul;
    verdict_t           early;
    logic [SHAMT_W-1:0] wm1;
    logic [LINE_W-1:0]  line;
    logic [DATA_W-1:0]  a;
    logic [DATA_W-1:0]  b;
    logic [DATA_W-1:0]  pp_ll;
    logic [DATA_W-1:0]  pp_lh;
    logic [DATA_W-1:0]  pp_hl;
    logic [DATA_W-1:0]  pp_hh;
  } soc_pp_t;

  // Full signed product, ready for the range check
  typedef struct packed {
    logic                valid;
    logic                is_mul;
    verdict_t            early;
    logic [SHAMT_W-1:0]  wm1;
    logic [LINE_W-1:0]   line;
    logic [2*DATA_W-1:0] prod;
  } soc_prod_t;

  // Sign-extend from bit OPERAND_BITS-1
  function automatic logic [DATA_W-1:0] sext_op(logic [DATA_W-1:0] v);
    logic signed [DATA_W-1:0] t;
    t = $signed(v << SEXT_SHIFT);
    return DATA_W'(t >>> SEXT_SHIFT);
  endfunction

  // Low word fits the width: bits [63:wm1] all match the sign
  function automatic logic low_fits(logic [DATA_W-1:0] low, logic sign,
                                    logic [SHAMT_W-1:0] wm1);
    logic [DATA_W-1:0] himask;
    himask = {DATA_W{1'b1}} << wm1;
    return ((low ^ {DATA_W{sign}}) & himask) == '0;
  endfunction

endpackage

### rtl/core/soc_prep.sv
// Operand decode, add/sub and divide checks, 32x32 partial products.
module soc_prep (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  soc_pkg::soc_in_t in_item,
  output soc_pkg::soc_pp_t pp
);
  import soc_pkg::*;

  logic               va_r;
  logic [MODE_W-1:0]  mode_r;
  logic [DATA_W-1:0]  a_r, b_r;
  logic [SHAMT_W-1:0] wm1_r, wm1_nxt;
  logic [LINE_W-1:0]  line_r;
  soc_pp_t            pp_r, pp_nxt;
  logic [DATA_W:0]    sum65;
  logic               sum_ok;
  logic [DATA_W-1:0]  min_w;

  // Stage A: width saturation, sign extension
  always_comb begin
    if (in_item.result_bits == '0 || in_item.result_bits > OPERAND_BITS_R) begin
      wm1_nxt = SHAMT_W'(OPERAND_BITS_R - 7'd1);
    end else begin
      wm1_nxt = SHAMT_W'(in_item.result_bits - 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= in_valid;
    end
    mode_r <= in_item.mode;
    a_r    <= sext_op(in_item.left_operand);
    b_r    <= sext_op(in_item.right_operand);
    wm1_r  <= wm1_nxt;
    line_r <= in_item.source_line;
  end

  // Stage B: exact 65-bit add/sub, divide checks, partial products
  always_comb begin
    if (mode_r == MODE_SUB) begin
      sum65 = {a_r[DATA_W-1], a_r} - {b_r[DATA_W-1], b_r};
    end else begin
      sum65 = {a_r[DATA_W-1], a_r} + {b_r[DATA_W-1], b_r};
    end
    sum_ok = low_fits(sum65[DATA_W-1:0], sum65[DATA_W], wm1_r);
    min_w  = {DATA_W{1'b1}} << wm1_r;

    pp_nxt        = pp_r;
    pp_nxt.valid  = va_r;
    pp_nxt.is_mul = (mode_r == MODE_MUL);
    pp_nxt.wm1    = wm1_r;
    pp_nxt.line   = line_r;
    pp_nxt.a      = a_r;
    pp_nxt.b      = b_r;
    pp_nxt.pp_ll  = a_r[HALF_W-1:0]      * b_r[HALF_W-1:0];
    pp_nxt.pp_lh  = a_r[HALF_W-1:0]      * b_r[DATA_W-1:HALF_W];
    pp_nxt.pp_hl  = a_r[DATA_W-1:HALF_W] * b_r[HALF_W-1:0];
    pp_nxt.pp_hh  = a_r[DATA_W-1:HALF_W] * b_r[DATA_W-1:HALF_W];
    pp_nxt.early  = VERDICT_OK;
    case (mode_r)
      MODE_ADD, MODE_SUB: begin
        if (!sum_ok) pp_nxt.early = VERDICT_OVERFLOW;
      end
      MODE_DIV, MODE_REM: begin
        if (b_r == '0) begin
          pp_nxt.early = VERDICT_DIVZERO;
        end else if (b_r == {DATA_W{1'b1}} && a_r == min_w) begin
          pp_nxt.early = VERDICT_OVERFLOW;
        end
      end
      default: pp_nxt.early = VERDICT_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_r <= '0;
    end else begin
      pp_r <= pp_nxt;
    end
  end

  assign pp = pp_r;

  // Zero-divisor verdict only ever comes from a zero divisor
  a_divzero: assert property (@(posedge clk) disable iff (!rst_n)
    (pp_r.valid && pp_r.early == VERDICT_DIVZERO) |-> (pp_r.b == '0 && !pp_r.is_mul))
    else $error("divide-by-zero verdict with nonzero divisor");

  // Multiply carries no early verdict
  a_mul_early: assert property (@(posedge clk) disable iff (!rst_n)
    (pp_r.valid && pp_r.is_mul) |-> (pp_r.early == VERDICT_OK))
    else $error("multiply item carries an early verdict");

endmodule

### rtl/core/soc_mul_sum.sv
// Two-stage reduction of the partial products to the exact signed product.
module soc_mul_sum (
  input  logic              clk,
  input  logic              rst_n,
  input  soc_pkg::soc_pp_t   pp,
  output soc_pkg::soc_prod_t prod
);
  import soc_pkg::*;

  logic               vc_r;
  logic               is_mul_r;
  verdict_t           early_r;
  logic [SHAMT_W-1:0] wm1_r;
  logic [LINE_W-1:0]  line_r;
  logic [DATA_W-1:0]  hh_r, ll_r;
  logic [DATA_W:0]    mid_r, mid_nxt;
  logic [DATA_W-1:0]  corr_r, corr_nxt;
  soc_prod_t          prod_r, prod_nxt;

  // Stage C: middle terms, and the signed correction to the high word
  always_comb begin
    mid_nxt  = {1'b0, pp.pp_lh} + {1'b0, pp.pp_hl};
    corr_nxt = (pp.a[DATA_W-1] ? pp.b : '0) + (pp.b[DATA_W-1] ? pp.a : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else begin
      vc_r <= pp.valid;
    end
    is_mul_r <= pp.is_mul;
    early_r  <= pp.early;
    wm1_r    <= pp.wm1;
    line_r   <= pp.line;
    hh_r     <= pp.pp_hh;
    ll_r     <= pp.pp_ll;
    mid_r    <= mid_nxt;
    corr_r   <= corr_nxt;
  end

  // Stage D: 128-bit product
  always_comb begin
    prod_nxt.valid  = vc_r;
    prod_nxt.is_mul = is_mul_r;
    prod_nxt.early  = early_r;
    prod_nxt.wm1    = wm1_r;
    prod_nxt.line   = line_r;
    prod_nxt.prod   = {hh_r, ll_r} + {(HALF_W-1)'(0), mid_r, HALF_W'(0)}
                    - {corr_r, DATA_W'(0)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r <= '0;
    end else begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

### rtl/core/soc_verdict.sv
// Final range check of the product and the result register.
module soc_verdict (
  input  logic              clk,
  input  logic              rst_n,
  input  soc_pkg::soc_prod_t prod,
  output logic              out_valid,
  output soc_pkg::soc_out_t  out_item
);
  import soc_pkg::*;

  logic     sign;
  logic     prod_ok;
  logic     valid_r;
  soc_out_t item_r, item_nxt;

  // Product fits when bits [127:w-1] all equal the sign
  always_comb begin
    sign    = prod.prod[2*DATA_W-1];
    prod_ok = (prod.prod[2*DATA_W-1:DATA_W] == {DATA_W{sign}})
           && low_fits(prod.prod[DATA_W-1:0], sign, prod.wm1);
    item_nxt.fault_line = prod.line;
    if (prod.is_mul) begin
      item_nxt.verdict = prod_ok ? VERDICT_OK : VERDICT_OVERFLOW;
    end else begin
      item_nxt.verdict = prod.early;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= prod.valid;
    end
    item_r <= item_nxt;
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

### rtl/core/signed_overflow_checker_top.sv
// Signed overflow checker: five-stage pipeline, one check per clock while busy is low.
// An accepted item passes the stage A, partial-product, stage C, product and result registers in turn.
// Throughput: one item per cycle; busy is low except in and just after reset.
// Partial products are 32x32; the product is summed over two more stages.
// Synchronous active-low reset flushes all stage valid bits.
// The receiver cannot stall: each result is shown for exactly one cycle.
module signed_overflow_checker_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  soc_pkg::soc_in_t  in_item,
  output logic             out_valid,
  output soc_pkg::soc_out_t out_item
);
  import soc_pkg::*;

  logic      busy_r;
  soc_pp_t   pp;
  soc_prod_t prod;

  // Busy only while in reset and the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  soc_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy_r),
    .in_item  (in_item),
    .pp       (pp)
  );

  soc_mul_sum u_mul_sum (
    .clk   (clk),
    .rst_n (rst_n),
    .pp    (pp),
    .prod  (prod)
  );

  soc_verdict u_verdict (
    .clk       (clk),
    .rst_n     (rst_n),
    .prod      (prod),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Every accepted item gives exactly one result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4)
     && $past(rst_n, 5)) |-> (out_valid == $past(start && !busy, 5)))
    else $error("result strobe does not match accepted item");

  // Tag travels with its item
  a_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3)
     && $past(rst_n, 4) && $past(rst_n, 5))
    |-> (out_item.fault_line == $past(in_item.source_line, 5)))
    else $error("fault line does not match accepted tag");

endmodule
